>>> rtl/core/i2cbb_pkg.sv
// shared types, command codes and constants of the i2c bit-bang master
`timescale 1ns / 1ps

package i2cbb_pkg;

   localparam int unsigned OP_W    = 3;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned STEP_W  = 5;
   localparam int unsigned PHASE_W = 16;
   localparam int unsigned ADDR_W  = 3;
   localparam int unsigned PDATA_W = 32;

   // command codes
   localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
   localparam logic [OP_W-1:0] OP_START     = 3'd1;
   localparam logic [OP_W-1:0] OP_STOP      = 3'd2;
   localparam logic [OP_W-1:0] OP_WRITE     = 3'd3;
   localparam logic [OP_W-1:0] OP_READ_ACK  = 3'd4;
   localparam logic [OP_W-1:0] OP_READ_NACK = 3'd5;

   // register word index
   localparam logic REG_PHASE_TICKS = 1'b0;

   localparam logic [PHASE_W-1:0] PHASE_RESET = 16'd20;

   typedef struct packed {
      logic               scl;
      logic               sda;
      logic [OP_W-1:0]    cmd;
      logic [STEP_W-1:0]  step;
      logic [PHASE_W-1:0] delay;
      logic [BYTE_W-1:0]  shift;
      logic [BYTE_W-1:0]  rx_byte;
   } bus_state_type;

   typedef struct packed {
      logic              scl;
      logic              sda;
      logic              busy;
      logic              done;
      logic [BYTE_W-1:0] read_data;
   } result_type;

   // number of bus delay intervals in each command
   function automatic logic [STEP_W-1:0] interval_total(input logic [OP_W-1:0] cmd);
      logic [STEP_W-1:0] total;
      unique case (cmd)
         OP_START:     total = 5'd2;
         OP_STOP:      total = 5'd3;
         OP_WRITE:     total = 5'd27;
         OP_READ_ACK:  total = 5'd19;
         OP_READ_NACK: total = 5'd19;
         default:      total = 5'd0;
      endcase
      return total;
   endfunction

endpackage

>>> rtl/core/i2cbb_csr.sv
// apb register block holding the bus delay interval length
`timescale 1ns / 1ps

module i2cbb_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [i2cbb_pkg::ADDR_W-1:0]  paddr,
   input  logic [i2cbb_pkg::PDATA_W-1:0] pwdata,
   output logic [i2cbb_pkg::PDATA_W-1:0] prdata,
   output logic                          pready,
   output logic [i2cbb_pkg::PHASE_W-1:0] phase_ticks
);
   import i2cbb_pkg::*;

   logic [PHASE_W-1:0] phase_ff;
   logic [PHASE_W-1:0] phase_in;
   logic               reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = (paddr[ADDR_W-1] == REG_PHASE_TICKS);

   always_comb begin
      phase_in = phase_ff;
      if (psel && penable && pwrite && pready && reg_sel) begin
         phase_in = pwdata[PHASE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_RESET;
      end else begin
         phase_ff <= phase_in;
      end
   end

   assign prdata      = reg_sel ? {{(PDATA_W-PHASE_W){1'b0}}, phase_ff} : '0;
   assign phase_ticks = phase_ff;

endmodule

>>> rtl/core/i2cbb_step.sv
// next-state logic for one tick or command of the bus sequencer
`timescale 1ns / 1ps

module i2cbb_step (
   input  i2cbb_pkg::bus_state_type       cur,
   input  logic [i2cbb_pkg::OP_W-1:0]     op,
   input  logic [i2cbb_pkg::BYTE_W-1:0]   data,
   input  logic                           sda_in,
   input  logic [i2cbb_pkg::PHASE_W-1:0]  phase_ticks,
   output i2cbb_pkg::bus_state_type       nxt,
   output i2cbb_pkg::result_type          res
);
   import i2cbb_pkg::*;

   logic [PHASE_W-1:0] ilen;
   logic [STEP_W-1:0]  step_inc;
   logic [7:0]         third_prod;
   logic [2:0]         third;
   logic [STEP_W-1:0]  bit_phase;
   logic               done;

   assign ilen     = (phase_ticks == '0) ? {{(PHASE_W-1){1'b0}}, 1'b1} : phase_ticks;
   assign step_inc = cur.step + 5'd1;

   // step mod 3 for steps below 24: step / 3 == (step * 11) >> 5
   assign third_prod = {3'd0, cur.step} * 8'd11;
   assign third      = third_prod[7:5];
   assign bit_phase  = cur.step - ({2'd0, third} + {1'b0, third, 1'b0});

   always_comb begin
      nxt  = cur;
      done = 1'b0;
      if (cur.cmd == OP_TICK) begin
         if (op != OP_TICK && op <= OP_READ_NACK) begin
            nxt.cmd   = op;
            nxt.step  = '0;
            nxt.delay = ilen;
            unique case (op)
               OP_START: begin
                  nxt.scl = 1'b1;
                  nxt.sda = 1'b1;
               end
               OP_STOP: begin
                  nxt.sda = 1'b0;
               end
               OP_WRITE: begin
                  nxt.shift = data;
               end
               default: begin
                  nxt.sda   = 1'b1;
                  nxt.shift = '0;
               end
            endcase
         end
      end else if (cur.delay > 16'd1) begin
         nxt.delay = cur.delay - 16'd1;
      end else begin
         // line changes at the end of the current interval
         unique case (cur.cmd)
            OP_START: begin
               if (cur.step == 5'd0) begin
                  nxt.sda = 1'b0;
               end else if (cur.step == 5'd1) begin
                  nxt.scl = 1'b0;
               end
            end
            OP_STOP: begin
               if (cur.step == 5'd0) begin
                  nxt.scl = 1'b1;
               end else if (cur.step == 5'd1) begin
                  nxt.sda = 1'b1;
               end
            end
            OP_WRITE: begin
               if (cur.step < 5'd24) begin
                  if (bit_phase == 5'd0) begin
                     nxt.sda = cur.shift[BYTE_W-1];
                  end else if (bit_phase == 5'd1) begin
                     nxt.scl   = 1'b1;
                     nxt.shift = {cur.shift[BYTE_W-2:0], 1'b0};
                  end else begin
                     nxt.scl = 1'b0;
                  end
               end else if (cur.step == 5'd25) begin
                  nxt.sda = 1'b1;
                  nxt.scl = 1'b1;
               end else if (cur.step == 5'd26) begin
                  nxt.scl = 1'b0;
                  nxt.sda = 1'b0;
               end
            end
            OP_READ_ACK, OP_READ_NACK: begin
               if (cur.step < 5'd16) begin
                  if (!cur.step[0]) begin
                     nxt.scl = 1'b1;
                  end else begin
                     nxt.shift = {cur.shift[BYTE_W-2:0], sda_in};
                     nxt.scl   = 1'b0;
                     if (cur.step == 5'd15) begin
                        nxt.sda = (cur.cmd == OP_READ_NACK);
                     end
                  end
               end else if (cur.step == 5'd16) begin
                  nxt.scl = 1'b1;
               end else if (cur.step == 5'd17) begin
                  nxt.scl = 1'b0;
               end
            end
            default: begin
            end
         endcase

         if (step_inc >= interval_total(cur.cmd)) begin
            if (cur.cmd >= OP_READ_ACK) begin
               nxt.rx_byte = nxt.shift;
            end
            nxt.cmd   = OP_TICK;
            nxt.step  = '0;
            nxt.delay = '0;
            done      = 1'b1;
         end else begin
            nxt.step  = step_inc;
            nxt.delay = ilen;
         end
      end
   end

   assign res.scl       = nxt.scl;
   assign res.sda       = nxt.sda;
   assign res.busy      = (nxt.cmd != OP_TICK);
   assign res.done      = done;
   assign res.read_data = nxt.rx_byte;

endmodule

>>> rtl/core/i2c_bit_bang_master.sv
// top level of the tick-driven i2c bit-bang master
//
// channel | direction | handshake               | payload
// req     | in        | req_valid / req_ready   | req_op, req_data, req_sda_in
// rsp     | out       | rsp_valid / rsp_ready   | rsp_scl, rsp_sda, rsp_busy_res,
//         |           |                         | rsp_done_res, rsp_read_data
// csr     | in/out    | psel, penable, pready   | paddr, pwrite, pwdata, prdata
//
// one item per clock cycle while the result register is empty or draining; its
// result appears in the result register in the cycle after the item is taken,
// set by the sequencer next-state logic between the state and result registers.
// a new item is taken whenever the result register is empty or being drained.
// synchronous reset releases both lines, idles the sequencer and loads 20
// ticks per interval; the result register starts empty.
`timescale 1ns / 1ps

module i2c_bit_bang_master (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [i2cbb_pkg::OP_W-1:0]    req_op,
   input  logic [i2cbb_pkg::BYTE_W-1:0]  req_data,
   input  logic                          req_sda_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_scl,
   output logic                          rsp_sda,
   output logic                          rsp_busy_res,
   output logic                          rsp_done_res,
   output logic [i2cbb_pkg::BYTE_W-1:0]  rsp_read_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [i2cbb_pkg::ADDR_W-1:0]  paddr,
   input  logic [i2cbb_pkg::PDATA_W-1:0] pwdata,
   output logic [i2cbb_pkg::PDATA_W-1:0] prdata,
   output logic                          pready
);
   import i2cbb_pkg::*;

   logic [PHASE_W-1:0] phase_ticks;
   bus_state_type      state_ff;
   bus_state_type      state_in;
   bus_state_type      state_nxt;
   result_type         res_nxt;
   result_type         res_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               accept;

   i2cbb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .phase_ticks (phase_ticks)
   );

   i2cbb_step u_step (
      .cur         (state_ff),
      .op          (req_op),
      .data        (req_data),
      .sda_in      (req_sda_in),
      .phase_ticks (phase_ticks),
      .nxt         (state_nxt),
      .res         (res_nxt)
   );

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign state_in     = accept ? state_nxt : state_ff;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.scl     <= 1'b1;
         state_ff.sda     <= 1'b1;
         state_ff.cmd     <= OP_TICK;
         state_ff.step    <= '0;
         state_ff.delay   <= '0;
         state_ff.shift   <= '0;
         state_ff.rx_byte <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded with each item
   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff <= res_nxt;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl       = res_ff.scl;
   assign rsp_sda       = res_ff.sda;
   assign rsp_busy_res  = res_ff.busy;
   assign rsp_done_res  = res_ff.done;
   assign rsp_read_data = res_ff.read_data;

endmodule

>>> sim/i2c_bit_bang_master_tb.sv
// self-checking testbench of the i2c bit-bang master: directed table, then random phases
`timescale 1ns / 1ps

module i2c_bit_bang_master_tb;
   import i2cbb_pkg::*;

   // op codes the block treats as a plain tick
   localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

   localparam logic [ADDR_W-1:0] CSR_PHASE_ADDR = {REG_PHASE_TICKS, 2'b00};
   localparam logic [ADDR_W-1:0] CSR_SPARE_ADDR = {~REG_PHASE_TICKS, 2'b00};

   localparam result_type RES_NONE  = '0;
   localparam result_type RES_IDLE  = '{scl: 1'b1, sda: 1'b1, busy: 1'b0, done: 1'b0,
                                        read_data: 8'h00};
   localparam result_type RES_START = '{scl: 1'b1, sda: 1'b1, busy: 1'b1, done: 1'b0,
                                        read_data: 8'h00};

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {XF_START, XF_ADDR, XF_BODY, XF_STOP} xfer_phase_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [OP_W-1:0]    op;
      logic [BYTE_W-1:0]  data;
      logic               sda_in;
      logic               typed;
      result_type         want;
      logic [ADDR_W-1:0]  addr;
      logic [PDATA_W-1:0] wdata;
   } dir_row_type;

   // kind, op, data, sda_in, typed, expected levels, csr address, csr data
   localparam dir_row_type DIRECTED [21] = '{
      '{ROW_ITEM, OP_TICK,      8'h00, 1'b0, 1'b1, RES_IDLE,  CSR_PHASE_ADDR, 32'h0},
      '{ROW_ITEM, OP_UNUSED_6,  8'hff, 1'b1, 1'b1, RES_IDLE,  CSR_PHASE_ADDR, 32'h0},
      '{ROW_ITEM, OP_UNUSED_7,  8'ha5, 1'b1, 1'b1, RES_IDLE,  CSR_PHASE_ADDR, 32'h0},
      '{ROW_CSR,  OP_TICK,      8'h00, 1'b0, 1'b0, RES_NONE,  CSR_SPARE_ADDR, 32'h3},
      '{ROW_CSR,  OP_TICK,      8'h00, 1'b0, 1'b0, RES_NONE,  CSR_PHASE_ADDR, 32'h0},
      '{ROW_ITEM, OP_START,     8'h00, 1'b0, 1'b1, RES_START, CSR_PHASE_ADDR, 32'h0},
      '{ROW_ITEM, OP_TICK,      8'h5a, 1'b1, 1'b0, RES_NONE,  CSR_PHASE_ADDR, 32'h0},
      '{ROW_ITEM, OP_READ_ACK,  8'hff, 1'b1, 1'b0, RES_NONE,  CSR_PHASE_ADDR, 32'h0},
      '{ROW_ITEM, OP_STOP,      8'h00, 1'b0, 1'b0, RES_NONE,  CSR_PHASE_ADDR, 32'h0},
      '{ROW_ITEM, OP_WRITE,     8'hff, 1'b0, 1'b0, RES_NONE,  CSR_PHASE_ADDR, 32'h0},
      '{ROW_ITEM, OP_TICK,      8'h00, 1'b1, 1'b0, RES_NONE,  CSR_PHASE_ADDR, 32'h0},
      '{ROW_ITEM, OP_TICK,      8'hff, 1'b0, 1'b0, RES_NONE,  CSR_PHASE_ADDR, 32'h0},
      '{ROW_CSR,  OP_TICK,      8'h00, 1'b0, 1'b0, RES_NONE,  CSR_PHASE_ADDR, 32'hffff0001},
      '{ROW_ITEM, OP_WRITE,     8'hff, 1'b1, 1'b0, RES_NONE,  CSR_PHASE_ADDR, 32'h0},
      '{ROW_ITEM, OP_READ_NACK, 8'h00, 1'b0, 1'b0, RES_NONE,  CSR_PHASE_ADDR, 32'h0},
      '{ROW_ITEM, OP_TICK,      8'h81, 1'b1, 1'b0, RES_NONE,  CSR_PHASE_ADDR, 32'h0},
      '{ROW_ITEM, OP_TICK,      8'h00, 1'b0, 1'b0, RES_NONE,  CSR_PHASE_ADDR, 32'h0},
      '{ROW_ITEM, OP_TICK,      8'hff, 1'b1, 1'b0, RES_NONE,  CSR_PHASE_ADDR, 32'h0},
      '{ROW_ITEM, OP_UNUSED_6,  8'h3c, 1'b0, 1'b0, RES_NONE,  CSR_PHASE_ADDR, 32'h0},
      '{ROW_ITEM, OP_UNUSED_7,  8'hc3, 1'b1, 1'b0, RES_NONE,  CSR_PHASE_ADDR, 32'h0},
      '{ROW_ITEM, OP_TICK,      8'h00, 1'b0, 1'b0, RES_NONE,  CSR_PHASE_ADDR, 32'h0}
   };

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [OP_W-1:0]     req_op;
   logic [BYTE_W-1:0]   req_data;
   logic                req_sda_in;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_scl;
   logic                rsp_sda;
   logic                rsp_busy_res;
   logic                rsp_done_res;
   logic [BYTE_W-1:0]   rsp_read_data;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [PDATA_W-1:0]  pwdata;
   logic [PDATA_W-1:0]  prdata;
   logic                pready;

   // predicted bus sequencer and its register
   bus_state_type       bus_model;
   logic [PHASE_W-1:0]  phase_cfg;
   result_type          expected_levels [$];

   xfer_phase_type      xfer_pos;
   int                  xfer_len;
   logic                xfer_read;

   int send_idle_pct;
   int rcv_stall_pct;
   int hold_left;
   int err_count;
   int items_sent;
   int results_checked;
   int cmds_finished;
   int cfg_writes;

   i2c_bit_bang_master dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_data      (req_data),
      .req_sda_in    (req_sda_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_scl       (rsp_scl),
      .rsp_sda       (rsp_sda),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_read_data (rsp_read_data),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(8_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic report_mismatch(input string what);
      err_count++;
      if (err_count <= 50) $display("mismatch: %s", what);
   endtask

   function automatic logic [STEP_W-1:0] steps_in(input logic [OP_W-1:0] cmd);
      case (cmd)
         OP_START:                  return 5'd2;
         OP_STOP:                   return 5'd3;
         OP_WRITE:                  return 5'd27;
         OP_READ_ACK, OP_READ_NACK: return 5'd19;
         default:                   return 5'd0;
      endcase
   endfunction

   function automatic logic [PHASE_W-1:0] ticks_per_step();
      // zero behaves as one tick per interval
      return (phase_cfg == '0) ? PHASE_W'(1) : phase_cfg;
   endfunction

   // line changes made when interval idx of the running command ends
   task automatic line_changes(input logic [STEP_W-1:0] idx, input logic sin);
      case (bus_model.cmd)
         OP_START: begin
            if (idx == 0) bus_model.sda = 1'b0;
            else if (idx == 1) bus_model.scl = 1'b0;
         end
         OP_STOP: begin
            if (idx == 0) bus_model.scl = 1'b1;
            else if (idx == 1) bus_model.sda = 1'b1;
         end
         OP_WRITE: begin
            if (idx < 3 * BYTE_W) begin
               case (idx % 3)
                  0: bus_model.sda = bus_model.shift[BYTE_W-1];
                  1: begin
                     bus_model.scl = 1'b1;
                     bus_model.shift = bus_model.shift << 1;
                  end
                  default: bus_model.scl = 1'b0;
               endcase
            end else if (idx == 3 * BYTE_W + 1) begin
               bus_model.sda = 1'b1;
               bus_model.scl = 1'b1;
            end else if (idx == 3 * BYTE_W + 2) begin
               bus_model.scl = 1'b0;
               bus_model.sda = 1'b0;
            end
         end
         OP_READ_ACK, OP_READ_NACK: begin
            if (idx < 2 * BYTE_W) begin
               if (!idx[0]) begin
                  bus_model.scl = 1'b1;
               end else begin
                  bus_model.shift = {bus_model.shift[BYTE_W-2:0], sin};
                  bus_model.scl = 1'b0;
                  // ack or nack goes out after the last data bit
                  if (idx == 2 * BYTE_W - 1) bus_model.sda = (bus_model.cmd == OP_READ_NACK);
               end
            end else if (idx == 2 * BYTE_W) begin
               bus_model.scl = 1'b1;
            end else if (idx == 2 * BYTE_W + 1) begin
               bus_model.scl = 1'b0;
            end
         end
         default: ;
      endcase
   endtask

   // one step of the sequencer per accepted item; OP_TICK in cmd means idle
   task automatic advance_bus(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                              input logic sin, output result_type levels);
      logic done;
      done = 1'b0;
      if (bus_model.cmd == OP_TICK) begin
         if (op >= OP_START && op <= OP_READ_NACK) begin
            bus_model.cmd = op;
            bus_model.step = '0;
            bus_model.delay = ticks_per_step();
            case (op)
               OP_START: begin
                  bus_model.scl = 1'b1;
                  bus_model.sda = 1'b1;
               end
               OP_STOP:  bus_model.sda = 1'b0;
               OP_WRITE: bus_model.shift = data;
               default: begin
                  bus_model.sda = 1'b1;
                  bus_model.shift = '0;
               end
            endcase
         end
      end else if (bus_model.delay > 1) begin
         bus_model.delay = bus_model.delay - 1'b1;
      end else begin
         line_changes(bus_model.step, sin);
         bus_model.step = bus_model.step + 1'b1;
         if (bus_model.step >= steps_in(bus_model.cmd)) begin
            if (bus_model.cmd >= OP_READ_ACK) bus_model.rx_byte = bus_model.shift;
            bus_model.cmd = OP_TICK;
            bus_model.step = '0;
            bus_model.delay = '0;
            done = 1'b1;
         end else begin
            bus_model.delay = ticks_per_step();
         end
      end
      levels = '{scl: bus_model.scl, sda: bus_model.sda, busy: bus_model.cmd != OP_TICK,
                 done: done, read_data: bus_model.rx_byte};
   endtask

   task automatic send_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                            input logic sin, input logic use_typed, input result_type typed);
      result_type levels;
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_data <= BYTE_W'($urandom);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_data <= data;
      req_sda_in <= sin;
      do @(posedge clock); while (!req_ready);
      advance_bus(op, data, sin, levels);
      expected_levels.push_back(use_typed ? typed : levels);
      items_sent++;
   endtask

   task automatic park_sender();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic finish_command();
      while (bus_model.cmd != OP_TICK)
         send_item(OP_TICK, BYTE_W'($urandom), 1'($urandom), 1'b0, RES_NONE);
   endtask

   task automatic apb_cycle(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // bring the block to idle, write a register, then read phase_ticks back
   task automatic reconfigure(input logic [ADDR_W-1:0] addr, input logic [PDATA_W-1:0] value);
      logic [PDATA_W-1:0] rd;
      finish_command();
      park_sender();
      while (expected_levels.size() != 0) @(posedge clock);
      apb_cycle(1'b1, addr, value, rd);
      if (addr == CSR_PHASE_ADDR) phase_cfg = value[PHASE_W-1:0];
      cfg_writes++;
      apb_cycle(1'b0, CSR_PHASE_ADDR, '0, rd);
      if (rd !== PDATA_W'(phase_cfg))
         report_mismatch($sformatf("phase_ticks read %0h want %0h", rd, phase_cfg));
   endtask

   task automatic run_phase(input int count, input int send_pct, input int stall_pct,
                            input logic pressure);
      logic [OP_W-1:0] op;
      logic            busy;
      int              sent;
      int              taken;
      send_idle_pct = send_pct;
      rcv_stall_pct = stall_pct;
      sent = 0;
      taken = 0;
      while (taken < count) begin
         busy = (bus_model.cmd != OP_TICK);
         if (busy) begin
            op = ($urandom_range(99) < 92) ? OP_TICK : OP_W'($urandom_range(1, 7));
         end else if ($urandom_range(99) < 80) begin
            // well-formed transfer: start, address byte, body, stop
            case (xfer_pos)
               XF_START: begin
                  op = OP_START;
                  xfer_len = $urandom_range(1, 3);
                  xfer_pos = XF_ADDR;
               end
               XF_ADDR: begin
                  op = OP_WRITE;
                  xfer_read = 1'($urandom);
                  xfer_pos = XF_BODY;
               end
               XF_BODY: begin
                  if (xfer_len > 1) begin
                     op = xfer_read ? OP_READ_ACK : OP_WRITE;
                     xfer_len--;
                  end else begin
                     op = xfer_read ? OP_READ_NACK : OP_WRITE;
                     xfer_pos = XF_STOP;
                  end
               end
               default: begin
                  op = OP_STOP;
                  xfer_pos = XF_START;
               end
            endcase
         end else begin
            op = OP_W'($urandom_range(7));
         end
         send_item(op, BYTE_W'($urandom), 1'($urandom), 1'b0, RES_NONE);
         sent++;
         // a command that lands while busy is simply ignored
         if (!(busy && op >= OP_START && op <= OP_READ_NACK)) taken++;
         if (pressure && sent == 40) hold_left = 300;
         if (pressure && sent == 150) begin
            park_sender();
            while (expected_levels.size() != 0) @(posedge clock);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [BYTE_W-1:0] got,
                              input logic [BYTE_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                   results_checked, name, got, want));
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_levels.size() == 0) begin
            report_mismatch("result with no item pending");
         end else begin
            want = expected_levels.pop_front();
            check_field("scl", BYTE_W'(rsp_scl), BYTE_W'(want.scl));
            check_field("sda", BYTE_W'(rsp_sda), BYTE_W'(want.sda));
            check_field("busy", BYTE_W'(rsp_busy_res), BYTE_W'(want.busy));
            check_field("done", BYTE_W'(rsp_done_res), BYTE_W'(want.done));
            check_field("read_data", rsp_read_data, want.read_data);
            results_checked++;
            if (want.done) cmds_finished++;
         end
      end
   end

   // result side: random stalls plus an occasional long hold-off
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_TICK;
      req_data = '0;
      req_sda_in = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      bus_model = '{scl: 1'b1, sda: 1'b1, default: '0};
      phase_cfg = PHASE_RESET;
      xfer_pos = XF_START;
      xfer_len = 0;
      xfer_read = 1'b0;
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      hold_left = 0;
      err_count = 0;
      items_sent = 0;
      results_checked = 0;
      cmds_finished = 0;
      cfg_writes = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[k]) begin
         if (DIRECTED[k].kind == ROW_CSR)
            reconfigure(DIRECTED[k].addr, DIRECTED[k].wdata);
         else
            send_item(DIRECTED[k].op, DIRECTED[k].data, DIRECTED[k].sda_in,
                      DIRECTED[k].typed, DIRECTED[k].want);
      end

      run_phase(200, 0, 0, 1'b0);
      reconfigure(CSR_PHASE_ADDR, 32'd2);
      run_phase(200, 61, 0, 1'b0);
      reconfigure(CSR_PHASE_ADDR, 32'd0);
      run_phase(200, 0, 61, 1'b0);
      reconfigure(CSR_PHASE_ADDR, 32'd3);
      run_phase(200, 28, 28, 1'b0);
      reconfigure(CSR_PHASE_ADDR, PDATA_W'($urandom_range(1, 4)));
      run_phase(180, 0, 0, 1'b1);

      // widest interval value reads back, then a start runs out a long count
      reconfigure(CSR_PHASE_ADDR, 32'h0000_ffff);
      reconfigure(CSR_PHASE_ADDR, 32'h0000_0020);
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      send_item(OP_START, BYTE_W'($urandom), 1'($urandom), 1'b0, RES_NONE);
      finish_command();

      reconfigure(CSR_PHASE_ADDR, 32'd1);
      run_phase(120, 61, 61, 1'b0);

      park_sender();
      for (int w = 0; w < 5000 && expected_levels.size() != 0; w++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (expected_levels.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_levels.size()));

      $display("covered %0d items across %0d register writes, %0d bus commands finished",
               items_sent, cfg_writes, cmds_finished);
      $display("compared %0d results, %0d mismatches", results_checked, err_count);
      if (err_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> i2c_bit_bang_master.f
rtl/core/i2cbb_pkg.sv
rtl/core/i2cbb_csr.sv
rtl/core/i2cbb_step.sv
rtl/core/i2c_bit_bang_master.sv
sim/i2c_bit_bang_master_tb.sv
